// ===== rtl/core/pcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Percent decoder package
// Shared types and helpers for the percent URL decoder.
// ----------------------------------------------------------------------------
package pcd_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;
   localparam int unsigned MAX_BEATS = 3;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_PCT   = 2'd1,
      PEND_DIGIT = 2'd2
   } pend_type;

   typedef struct packed {
      pend_type   pend;
      logic [7:0] held;
   } state_type;

   typedef struct packed {
      logic [1:0]                     count;
      logic [MAX_BEATS-1:0][7:0]      bytes;
      logic                           last;
   } grp_type;

   // Returns {is_hex, nibble}.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/pcd_decode.sv =====
// ----------------------------------------------------------------------------
// Percent decoder step logic
// Turns one raw byte and the pending escape state into a group of up to
// three output beats and the next pending state.
// ----------------------------------------------------------------------------
module pcd_decode import pcd_pkg::*; (
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  state_type  state,
   output state_type  state_nxt,
   output grp_type    grp
);

   always_comb begin
      logic [4:0] hx;
      logic [4:0] hy;
      logic [7:0] v;
      logic [1:0] n;
      hx        = hex_value(state.held);
      hy        = hex_value(in_byte);
      v         = 8'd0;
      n         = 2'd0;
      grp       = '0;
      state_nxt = state;
      if (hx[4]) begin
         v = hy[4] ? {hx[3:0], hy[3:0]} : {4'd0, hx[3:0]};
      end
      case (state.pend)
         PEND_PCT: begin
            state_nxt.held = in_byte;
            state_nxt.pend = PEND_DIGIT;
         end
         PEND_DIGIT: begin
            state_nxt.pend = PEND_NONE;
            if (v != 8'd0) begin
               grp.bytes[n] = v;
               n = n + 2'd1;
            end else begin
               grp.bytes[n] = PCT_CHAR;
               n = n + 2'd1;
               if (state.held == PCT_CHAR) begin
                  state_nxt.held = in_byte;
                  state_nxt.pend = PEND_DIGIT;
               end else begin
                  grp.bytes[n] = state.held;
                  n = n + 2'd1;
                  if (in_byte == PCT_CHAR) begin
                     state_nxt.pend = PEND_PCT;
                  end else begin
                     grp.bytes[n] = in_byte;
                     n = n + 2'd1;
                  end
               end
            end
         end
         default: begin
            state_nxt.pend = PEND_NONE;
            if (in_byte == PCT_CHAR) begin
               state_nxt.pend = PEND_PCT;
            end else begin
               grp.bytes[n] = in_byte;
               n = n + 2'd1;
            end
         end
      endcase
      if (in_last) begin
         if (state_nxt.pend == PEND_PCT) begin
            grp.bytes[n] = PCT_CHAR;
            n = n + 2'd1;
         end else if (state_nxt.pend == PEND_DIGIT) begin
            grp.bytes[n] = PCT_CHAR;
            n = n + 2'd1;
            grp.bytes[n] = state_nxt.held;
            n = n + 2'd1;
         end
         state_nxt.pend = PEND_NONE;
      end
      grp.count = n;
      grp.last  = in_last;
   end

endmodule

// ===== rtl/core/pcd_emit.sv =====
// ----------------------------------------------------------------------------
// Percent decoder output stage
// Holds one decoded group and sends its bytes out one beat at a time.
// ----------------------------------------------------------------------------
module pcd_emit import pcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load_valid,
   input  grp_type    load_grp,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic       valid_ff;
   logic       valid_in;
   grp_type    grp_ff;
   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic       end_beat;
   logic       take;
   logic       done;
   logic       load;

   assign end_beat     = idx_ff == (grp_ff.count - 2'd1);
   assign take         = valid_ff && !rsp_stall;
   assign done         = take && end_beat;
   assign free         = !valid_ff || done;
   assign load         = load_valid && free;
   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = grp_ff.bytes[idx_ff];
   assign rsp_out_last = grp_ff.last && end_beat;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = load_grp.count != 2'd0;
         idx_in   = 2'd0;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= load_grp;
      end
   end

endmodule

// ===== rtl/core/percent_url_decoder.sv =====
// ----------------------------------------------------------------------------
// Percent URL decoder
// A byte passes the input register, then the output register, before its
// first beat shows. Throughput: one byte per cycle while rsp_stall is low
// and bytes yield at most one beat; else input waits for the output stage.
// Reset clears the input and output valids and the pending escape state.
// ----------------------------------------------------------------------------
module percent_url_decoder import pcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   pend_type   pend_ff;
   logic [7:0] held_ff;
   state_type  state;
   state_type  state_in;
   grp_type    grp;
   logic       free;
   logic       advance;

   assign state.pend = pend_ff;
   assign state.held = held_ff;
   assign advance    = in_valid_ff && free;
   assign req_stall  = in_valid_ff && !free;

   pcd_decode u_decode (
      .in_byte   (in_byte_ff),
      .in_last   (in_last_ff),
      .state     (state),
      .state_nxt (state_in),
      .grp       (grp)
   );

   pcd_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .load_valid   (in_valid_ff),
      .load_grp     (grp),
      .free         (free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pend_ff     <= PEND_NONE;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            pend_ff <= state_in.pend;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
      if (advance) begin
         held_ff <= state_in.held;
      end
   end

endmodule

// ===== bench/tb_percent_url_decoder.sv =====
// ----------------------------------------------------------------------------
// Percent URL decoder testbench
// Streams strings of raw bytes into the decoder and predicts every decoded
// beat from a local model of the escape parser. Each output beat is checked
// in order against the predicted beats. Both sides idle at random, except in
// the final full-rate phase.
// ----------------------------------------------------------------------------
module tb_percent_url_decoder;
   timeunit 1ns;
   timeprecision 1ps;
   import pcd_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int RANDOM_BYTES = 60;
   localparam int FULL_RATE_BYTES = 30;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } decoded_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   decoded_beat_type decoded_q[$];
   pend_type    escape_state = PEND_NONE;
   logic [7:0]  held_x = 8'h00;
   int          mismatches = 0;
   int          bytes_sent = 0;
   int          cycle_count = 0;
   int          stall_left = 0;
   bit          calm = 1'b0;

   percent_url_decoder u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   always #6 clock = ~clock;

   function automatic int digit_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
   endfunction

   function automatic logic [7:0] random_hex_digit();
      case ($urandom_range(0, 2))
         0: return 8'h30 + 8'($urandom_range(0, 9));
         1: return 8'h41 + 8'($urandom_range(0, 5));
         default: return 8'h61 + 8'($urandom_range(0, 5));
      endcase
   endfunction

   function automatic logic [7:0] hex_border_byte();
      case ($urandom_range(0, 5))
         0: return 8'h2F;
         1: return 8'h3A;
         2: return 8'h40;
         3: return 8'h47;
         4: return 8'h60;
         default: return 8'h67;
      endcase
   endfunction

   task automatic decode_percent(input logic [7:0] b, input logic lst);
      logic [7:0] beats [0:2];
      int         n;
      int         hx;
      int         hy;
      int         value;
      n = 0;
      case (escape_state)
         PEND_PCT: begin
            held_x = b;
            escape_state = PEND_DIGIT;
         end
         PEND_DIGIT: begin
            hx = digit_value(held_x);
            hy = digit_value(b);
            value = 0;
            if (hx >= 0) begin
               value = (hy >= 0) ? hx * 16 + hy : hx;
            end
            escape_state = PEND_NONE;
            if (value != 0) begin
               beats[n] = value[7:0];
               n++;
            end else begin
               // A zero escape passes the percent sign and rescans both digits.
               beats[n] = PCT_CHAR;
               n++;
               if (held_x == PCT_CHAR) begin
                  escape_state = PEND_PCT;
               end else begin
                  beats[n] = held_x;
                  n++;
               end
               if (escape_state == PEND_PCT) begin
                  held_x = b;
                  escape_state = PEND_DIGIT;
               end else if (b == PCT_CHAR) begin
                  escape_state = PEND_PCT;
               end else begin
                  beats[n] = b;
                  n++;
               end
            end
         end
         default: begin
            escape_state = PEND_NONE;
            if (b == PCT_CHAR) begin
               escape_state = PEND_PCT;
            end else begin
               beats[n] = b;
               n++;
            end
         end
      endcase
      if (lst) begin
         if (escape_state == PEND_PCT) begin
            beats[n] = PCT_CHAR;
            n++;
         end else if (escape_state == PEND_DIGIT) begin
            beats[n] = PCT_CHAR;
            n++;
            beats[n] = held_x;
            n++;
         end
         escape_state = PEND_NONE;
      end
      for (int i = 0; i < n; i++) begin
         decoded_q.push_back({beats[i], lst && (i == n - 1)});
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic lst);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_in_last <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_percent(b, lst);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], i == s.len() - 1);
      end
   endtask

   task automatic send_random_string();
      logic [7:0] text[$];
      int         chunks;
      chunks = $urandom_range(1, 4);
      repeat (chunks) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               text.push_back(PCT_CHAR);
               text.push_back(random_hex_digit());
               text.push_back(random_hex_digit());
            end
            4: begin
               text.push_back(PCT_CHAR);
               text.push_back(8'h30);
               text.push_back($urandom_range(0, 1) ? random_hex_digit() : hex_border_byte());
            end
            5, 6: text.push_back(8'($urandom_range(0, 255)));
            7: text.push_back(PCT_CHAR);
            8: text.push_back(random_hex_digit());
            default: text.push_back(hex_border_byte());
         endcase
      end
      foreach (text[i]) begin
         send_byte(text[i], i == text.size() - 1);
      end
   endtask

   task automatic test_plain_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);
   endtask

   task automatic test_hex_escapes();
      send_text("%41");
      send_text("%fF");
      send_text("%1z");
   endtask

   task automatic test_literal_escapes();
      send_text("%0g");
      send_text("%zz");
      send_text("%%41");
   endtask

   task automatic test_end_while_holding();
      send_text("%");
      send_text("a%4");
   endtask

   task automatic test_random_strings();
      int stop_at;
      stop_at = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < stop_at) send_random_string();
   endtask

   task automatic test_full_rate();
      int stop_at;
      calm = 1'b1;
      stop_at = bytes_sent + FULL_RATE_BYTES;
      while (bytes_sent < stop_at) send_random_string();
   endtask

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      decoded_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            $error("unexpected beat: out_byte %h out_last %b", rsp_out_byte, rsp_out_last);
            mismatches++;
         end else begin
            want = decoded_q.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %h, actual %h", want.data, rsp_out_byte);
               mismatches++;
            end
            if (rsp_out_last !== want.last) begin
               $error("out_last: expected %b, actual %b", want.last, rsp_out_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_plain_bytes();
      test_hex_escapes();
      test_literal_escapes();
      test_end_while_holding();
      test_random_strings();
      test_full_rate();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/pcd_pkg.sv
rtl/core/pcd_decode.sv
rtl/core/pcd_emit.sv
rtl/core/percent_url_decoder.sv
bench/tb_percent_url_decoder.sv
